@@ design/tbom_pkg.sv @@
// Shared types and constants for the task budget overrun monitor.
package tbom_pkg;

  localparam int MAX_TASKS_DEF   = 8;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int RESULT_LIMIT    = 64;
  localparam int RES_CNT_W       = $clog2(RESULT_LIMIT + 1);
  localparam int QUEUE_DEPTH     = 2;

  localparam int OP_W     = 3;
  localparam int ID_W     = 3;
  localparam int PRIO_W   = 6;
  localparam int BUDGET_W = 32;
  localparam int NUM_W    = 4;
  localparam int CAUSE_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_START   = 3'd1,
    OP_END     = 3'd2,
    OP_PAUSE   = 3'd3,
    OP_UNPAUSE = 3'd4,
    OP_UPDATE  = 3'd5,
    OP_LOAD    = 3'd6
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [ID_W-1:0]     task_id;
    logic [PRIO_W-1:0]   prio;
    logic [BUDGET_W-1:0] budget;
    logic                critical;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAUSE,
    ST_WALK,
    ST_CHECK,
    ST_DROP,
    ST_FLUSH
  } state_t;

endpackage

@@ design/tbom_front.sv @@
// Request decode and filter, plus the short command queue toward the sequencer.
module tbom_front #(
  parameter int MAX_TASKS = tbom_pkg::MAX_TASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tbom_pkg::OP_W-1:0]     operation,
  input  logic [tbom_pkg::ID_W-1:0]     task_id,
  input  logic [tbom_pkg::PRIO_W-1:0]   priority_req,
  input  logic [tbom_pkg::BUDGET_W-1:0] budget,
  input  logic                          critical,
  output tbom_pkg::q_head_t             head,
  input  logic                          q_pop
);

  localparam int QD   = tbom_pkg::QUEUE_DEPTH;
  localparam int PW   = (QD > 1) ? $clog2(QD) : 1;
  localparam int FILW = $clog2(QD + 1);

  tbom_pkg::cmd_t slot [QD];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [FILW-1:0] fill;

  logic           keep;
  logic           id_ok;
  logic           push;
  tbom_pkg::cmd_t cmd_in;

  assign id_ok = int'(task_id) < MAX_TASKS;

  // Drop requests that change nothing: unused code, index outside the table.
  always_comb begin
    keep = 1'b0;
    case (operation)
      tbom_pkg::OP_TICK, tbom_pkg::OP_PAUSE,
      tbom_pkg::OP_UNPAUSE, tbom_pkg::OP_UPDATE: keep = 1'b1;
      tbom_pkg::OP_START, tbom_pkg::OP_END, tbom_pkg::OP_LOAD: keep = id_ok;
      default: keep = 1'b0;
    endcase
  end

  always_comb begin
    cmd_in.op       = tbom_pkg::op_t'(operation);
    cmd_in.task_id  = task_id;
    cmd_in.prio     = priority_req;
    cmd_in.budget   = budget;
    cmd_in.critical = critical;
  end

  assign in_ready   = fill != FILW'(QD);
  assign push       = in_valid && in_ready && keep;
  assign head.valid = fill != '0;
  assign head.cmd   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= cmd_in;
        wr_ptr <= (wr_ptr == PW'(QD - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(QD - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ design/tbom_back.sv @@
// Task table, elapsed counter and the sequencer that carries out each request.
module tbom_back #(
  parameter int MAX_TASKS   = tbom_pkg::MAX_TASKS_DEF,
  parameter int COUNT_WIDTH = tbom_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tbom_pkg::NUM_W-1:0]     cfg_wdata,
  input  tbom_pkg::q_head_t              head,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tbom_pkg::PRIO_W-1:0]    suspend_priority,
  output logic [tbom_pkg::CAUSE_W-1:0]   cause_task,
  output logic                           last
);

  localparam int IW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CTW = $clog2(MAX_TASKS + 1);

  tbom_pkg::state_t state, state_next;

  logic [tbom_pkg::NUM_W-1:0]  num_tasks;
  logic [COUNT_WIDTH-1:0]      elapsed;
  logic                        running  [MAX_TASKS];
  logic [COUNT_WIDTH-1:0]      used     [MAX_TASKS];
  logic [COUNT_WIDTH-1:0]      bud      [MAX_TASKS];
  logic [tbom_pkg::PRIO_W-1:0] prio_tab [MAX_TASKS];
  logic                        crit_tab [MAX_TASKS];

  logic [CTW-1:0]                 idx_i;
  logic [CTW-1:0]                 idx_j;
  logic [tbom_pkg::PRIO_W-1:0]    match_prio;
  logic [tbom_pkg::RES_CNT_W-1:0] res_cnt;
  logic                           pend_valid;
  logic [tbom_pkg::PRIO_W-1:0]    pend_prio;
  logic [tbom_pkg::CAUSE_W-1:0]   pend_cause;

  logic [CTW-1:0]         n_act;
  logic [IW-1:0]          ri;
  logic [IW-1:0]          rj;
  logic [IW-1:0]          tid;
  logic                   i_done;
  logic                   j_done;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] sat_sum;
  logic                   prio_hit;
  logic                   overrun;
  logic                   out_free;
  logic                   drop_hit;
  logic                   emit;
  logic                   drop_stall;
  logic                   flush_move;
  logic                   out_load;

  assign n_act  = (int'(num_tasks) > MAX_TASKS) ? CTW'(MAX_TASKS) : CTW'(num_tasks);
  assign ri     = idx_i[IW-1:0];
  assign rj     = idx_j[IW-1:0];
  assign tid    = IW'(head.cmd.task_id);
  assign i_done = idx_i >= n_act;
  assign j_done = idx_j >= n_act;

  // One saturating adder, shared by pause and update.
  assign sum     = {1'b0, used[ri]} + {1'b0, elapsed};
  assign sat_sum = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];

  assign prio_hit = prio_tab[ri] == match_prio;
  assign overrun  = used[ri] >= bud[ri];
  assign out_free = !out_valid || out_ready;

  // A result waits in the pending slot until the next one or the end of the walk
  // tells whether it is the last.
  assign drop_hit   = (state == tbom_pkg::ST_DROP) && !j_done && !crit_tab[rj];
  assign emit       = drop_hit && (res_cnt < tbom_pkg::RES_CNT_W'(tbom_pkg::RESULT_LIMIT));
  assign drop_stall = emit && pend_valid && !out_free;
  assign flush_move = (state == tbom_pkg::ST_FLUSH) && pend_valid && out_free;
  assign out_load   = (emit && pend_valid && out_free) || flush_move;
  assign q_pop      = (state == tbom_pkg::ST_IDLE) && head.valid;

  always_comb begin
    state_next = state;
    case (state)
      tbom_pkg::ST_IDLE: begin
        if (head.valid) begin
          if (head.cmd.op == tbom_pkg::OP_PAUSE) begin
            state_next = tbom_pkg::ST_PAUSE;
          end else if (head.cmd.op == tbom_pkg::OP_UPDATE) begin
            state_next = tbom_pkg::ST_WALK;
          end
        end
      end
      tbom_pkg::ST_PAUSE: begin
        if (i_done || prio_hit) state_next = tbom_pkg::ST_IDLE;
      end
      tbom_pkg::ST_WALK: begin
        if (i_done) begin
          state_next = tbom_pkg::ST_FLUSH;
        end else if (running[ri]) begin
          state_next = tbom_pkg::ST_CHECK;
        end
      end
      tbom_pkg::ST_CHECK: begin
        state_next = overrun ? tbom_pkg::ST_DROP : tbom_pkg::ST_WALK;
      end
      tbom_pkg::ST_DROP: begin
        if (j_done) state_next = tbom_pkg::ST_WALK;
      end
      tbom_pkg::ST_FLUSH: begin
        if (!pend_valid || out_free) state_next = tbom_pkg::ST_IDLE;
      end
      default: state_next = tbom_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tbom_pkg::ST_IDLE;
      num_tasks  <= '0;
      elapsed    <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      idx_i      <= '0;
      idx_j      <= '0;
      res_cnt    <= '0;
      match_prio <= '0;
      for (int k = 0; k < MAX_TASKS; k++) begin
        running[k]  <= 1'b0;
        used[k]     <= '0;
        bud[k]      <= '0;
        prio_tab[k] <= '0;
        crit_tab[k] <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) num_tasks <= cfg_wdata;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        tbom_pkg::ST_IDLE: begin
          if (head.valid) begin
            case (head.cmd.op)
              tbom_pkg::OP_TICK: begin
                if (!(&elapsed)) elapsed <= elapsed + 1'b1;
              end
              tbom_pkg::OP_START: begin
                running[tid] <= 1'b1;
                used[tid]    <= '0;
                elapsed      <= '0;
              end
              tbom_pkg::OP_END: running[tid] <= 1'b0;
              tbom_pkg::OP_PAUSE: begin
                idx_i      <= '0;
                match_prio <= head.cmd.prio;
              end
              tbom_pkg::OP_UNPAUSE: elapsed <= '0;
              tbom_pkg::OP_UPDATE: begin
                idx_i   <= '0;
                res_cnt <= '0;
              end
              tbom_pkg::OP_LOAD: begin
                bud[tid]      <= COUNT_WIDTH'(head.cmd.budget);
                prio_tab[tid] <= head.cmd.prio;
                crit_tab[tid] <= head.cmd.critical;
              end
              default: ;
            endcase
          end
        end
        tbom_pkg::ST_PAUSE: begin
          if (!i_done) begin
            if (prio_hit) begin
              if (running[ri]) used[ri] <= sat_sum;
            end else begin
              idx_i <= idx_i + 1'b1;
            end
          end
        end
        tbom_pkg::ST_WALK: begin
          if (!i_done) begin
            if (!running[ri]) begin
              idx_i <= idx_i + 1'b1;
            end else begin
              used[ri] <= sat_sum;
              elapsed  <= '0;
            end
          end
        end
        tbom_pkg::ST_CHECK: begin
          if (overrun) begin
            idx_j <= '0;
          end else begin
            idx_i <= idx_i + 1'b1;
          end
        end
        tbom_pkg::ST_DROP: begin
          if (j_done) begin
            idx_i <= idx_i + 1'b1;
          end else if (crit_tab[rj]) begin
            idx_j <= idx_j + 1'b1;
          end else if (!drop_stall) begin
            running[rj] <= 1'b0;
            idx_j       <= idx_j + 1'b1;
            if (emit) begin
              res_cnt <= res_cnt + 1'b1;
              if (pend_valid) begin
                suspend_priority <= pend_prio;
                cause_task       <= pend_cause;
                last             <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_prio  <= prio_tab[rj];
              pend_cause <= tbom_pkg::CAUSE_W'(idx_i);
            end
          end
        end
        tbom_pkg::ST_FLUSH: begin
          if (flush_move) begin
            suspend_priority <= pend_prio;
            cause_task       <= pend_cause;
            last             <= 1'b1;
            pend_valid       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ design/task_budget_overrun_monitor.sv @@
// Top level of the task budget overrun monitor.
// The front end takes one request per cycle, while not full, into a two-entry
// command queue; requests with an unused code, or a start, end or load whose
// task_id lies past the table, are dropped there. The sequencer behind it takes
// one request at a time; tick, start, end, unpause and load are carried out as
// they are popped. With N = min(num_tasks, MAX_TASKS): pause walks the entries
// up to and including the first priority match, or all N when none matches.
// Update walks every entry, adds and compares the budget of each running task,
// and for each overrun scans all N entries, handing out one suspend result for
// each non-critical task, before it resumes the walk; it then ends the walk and
// releases the final result. A suspend stalls the scan only while the output
// register and the result held behind it are both full and the output is not
// being taken. At most 64 results per update are delivered; later drops still
// stop their tasks.
module task_budget_overrun_monitor #(
  parameter int MAX_TASKS   = tbom_pkg::MAX_TASKS_DEF,
  parameter int COUNT_WIDTH = tbom_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tbom_pkg::NUM_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tbom_pkg::OP_W-1:0]     operation,
  input  logic [tbom_pkg::ID_W-1:0]     task_id,
  input  logic [tbom_pkg::PRIO_W-1:0]   priority_req,
  input  logic [tbom_pkg::BUDGET_W-1:0] budget,
  input  logic                          critical,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tbom_pkg::PRIO_W-1:0]   suspend_priority,
  output logic [tbom_pkg::CAUSE_W-1:0]  cause_task,
  output logic                          last
);

  tbom_pkg::q_head_t head;
  logic              q_pop;

  tbom_front #(
    .MAX_TASKS (MAX_TASKS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .task_id      (task_id),
    .priority_req (priority_req),
    .budget       (budget),
    .critical     (critical),
    .head         (head),
    .q_pop        (q_pop)
  );

  tbom_back #(
    .MAX_TASKS   (MAX_TASKS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .head             (head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .suspend_priority (suspend_priority),
    .cause_task       (cause_task),
    .last             (last)
  );

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> head.valid)
    else $error("command popped from an empty queue");

  a_full_means_nonempty: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> head.valid)
    else $error("queue refuses requests while holding none");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready && !head.valid)
    else $error("reset left a result or a queued command");

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the task budget overrun monitor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_T          = tbom_pkg::MAX_TASKS_DEF;
  localparam int ITEM_TARGET    = 420;
  localparam int SETTLE_CYCLES  = 200;
  localparam int HOLDOFF_CYCLES = 400;
  localparam logic [tbom_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

  localparam int RX_STEADY  = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;

  typedef struct packed {
    logic [tbom_pkg::PRIO_W-1:0]  prio;
    logic [tbom_pkg::CAUSE_W-1:0] cause;
    logic                         is_last;
  } drop_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [tbom_pkg::NUM_W-1:0]    cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [tbom_pkg::OP_W-1:0]     operation = '0;
  logic [tbom_pkg::ID_W-1:0]     task_id = '0;
  logic [tbom_pkg::PRIO_W-1:0]   priority_req = '0;
  logic [tbom_pkg::BUDGET_W-1:0] budget = '0;
  logic                          critical = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [tbom_pkg::PRIO_W-1:0]   suspend_priority;
  logic [tbom_pkg::CAUSE_W-1:0]  cause_task;
  logic                          last;

  // Predicted block state
  logic [tbom_pkg::NUM_W-1:0]  table_size = '0;
  logic [31:0]                 pooled_ticks = '0;
  logic                        running [MAX_T];
  logic [31:0]                 used [MAX_T];
  logic [31:0]                 allowance [MAX_T];
  logic [tbom_pkg::PRIO_W-1:0] level [MAX_T];
  logic                        is_crit [MAX_T];

  drop_t pending_drops[$];

  int  mismatches = 0;
  int  requests_sent = 0;
  int  drops_expected = 0;
  int  drops_checked = 0;
  int  sizes_written = 0;
  int  burst_left = 0;
  bit  sender_gaps = 1'b0;
  int  rx_mode = RX_STEADY;
  logic [2:0] rx_phase = '0;
  logic holding_off = 1'b0;
  event holdoff_go;

  task_budget_overrun_monitor DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .task_id          (task_id),
    .priority_req     (priority_req),
    .budget           (budget),
    .critical         (critical),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .suspend_priority (suspend_priority),
    .cause_task       (cause_task),
    .last             (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  // Advance the predicted state by one request and queue the suspends it causes.
  task automatic account_request(input logic [tbom_pkg::OP_W-1:0] op,
                                 input logic [tbom_pkg::ID_W-1:0] id,
                                 input logic [tbom_pkg::PRIO_W-1:0] prio,
                                 input logic [31:0] bud, input logic crit);
    int unsigned n;
    drop_t batch[$];
    drop_t one;
    n = (table_size > MAX_T) ? MAX_T : table_size;
    case (op)
      tbom_pkg::OP_TICK: pooled_ticks = add_clamped(pooled_ticks, 32'd1);
      tbom_pkg::OP_START: begin
        if (id < MAX_T) begin
          running[id] = 1'b1;
          used[id] = '0;
          pooled_ticks = '0;
        end
      end
      tbom_pkg::OP_END: if (id < MAX_T) running[id] = 1'b0;
      tbom_pkg::OP_PAUSE: begin
        // only the first matching entry counts, running or not
        for (int i = 0; i < n; i++) begin
          if (level[i] == prio) begin
            if (running[i]) used[i] = add_clamped(used[i], pooled_ticks);
            break;
          end
        end
      end
      tbom_pkg::OP_UNPAUSE: pooled_ticks = '0;
      tbom_pkg::OP_UPDATE: begin
        for (int i = 0; i < n; i++) begin
          if (running[i]) begin
            used[i] = add_clamped(used[i], pooled_ticks);
            pooled_ticks = '0;
            if (used[i] >= allowance[i]) begin
              for (int j = 0; j < n; j++) begin
                if (!is_crit[j]) begin
                  if (batch.size() < tbom_pkg::RESULT_LIMIT) begin
                    one.prio = level[j];
                    one.cause = tbom_pkg::CAUSE_W'(i);
                    one.is_last = 1'b0;
                    batch.push_back(one);
                  end
                  running[j] = 1'b0;
                end
              end
            end
          end
        end
        if (batch.size() > 0) batch[batch.size() - 1].is_last = 1'b1;
      end
      tbom_pkg::OP_LOAD: begin
        if (id < MAX_T) begin
          allowance[id] = bud;
          level[id] = prio;
          is_crit[id] = crit;
        end
      end
      default: ;
    endcase
    foreach (batch[k]) pending_drops.push_back(batch[k]);
    drops_expected += batch.size();
  endtask

  task automatic clear_prediction();
    pooled_ticks = '0;
    for (int i = 0; i < MAX_T; i++) begin
      running[i] = 1'b0;
      used[i] = '0;
      allowance[i] = '0;
      level[i] = '0;
      is_crit[i] = 1'b0;
    end
  endtask

  task automatic send_request(input logic [tbom_pkg::OP_W-1:0] op,
                              input logic [tbom_pkg::ID_W-1:0] id,
                              input logic [tbom_pkg::PRIO_W-1:0] prio,
                              input logic [31:0] bud, input logic crit);
    if (sender_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    if (burst_left > 0) burst_left--;
    in_valid     <= 1'b1;
    operation    <= op;
    task_id      <= id;
    priority_req <= prio;
    budget       <= bud;
    critical     <= crit;
    do @(posedge clk); while (!in_ready);
    account_request(op, id, prio, bud, crit);
    if (op != OP_UNUSED) requests_sent++;
  endtask

  // Drop valid, let every pending suspend arrive, then cover in-flight work.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_drops.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_table_size(input logic [tbom_pkg::NUM_W-1:0] size);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
    table_size = size;
    sizes_written++;
  endtask

  function automatic logic [31:0] pick_budget();
    case ($urandom_range(0, 9))
      6: return '0;
      7: return '1;
      8: return $urandom;
      9: return $urandom_range(13, 60);
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  // Favor a small pool so pause lookups hit
  function automatic logic [tbom_pkg::PRIO_W-1:0] pick_prio();
    if ($urandom_range(0, 9) < 7) return tbom_pkg::PRIO_W'($urandom_range(0, 3));
    return tbom_pkg::PRIO_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [tbom_pkg::NUM_W-1:0] pick_size();
    case ($urandom_range(0, 5))
      0: return 4'd0;
      1: return 4'd15;
      2: return 4'd8;
      default: return tbom_pkg::NUM_W'($urandom_range(1, 15));
    endcase
  endfunction

  always @(posedge clk) begin
    rx_phase <= (rx_phase == 3'd6) ? 3'd0 : rx_phase + 3'd1;
    if (rst || holding_off) begin
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        default:   out_ready <= (rx_phase >= 3'd3);
      endcase
    end
  end

  always begin
    @(holdoff_go);
    holding_off <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    holding_off <= 1'b0;
  end

  always @(posedge clk) begin
    drop_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_drops.size() == 0) begin
        $display("%0t: unexpected suspend, expected none, got prio %0d cause %0d last %0b",
                 $time, suspend_priority, cause_task, last);
        mismatches++;
      end else begin
        want = pending_drops.pop_front();
        drops_checked++;
        if (suspend_priority !== want.prio) begin
          $display("%0t: suspend_priority expected %0d, got %0d",
                   $time, want.prio, suspend_priority);
          mismatches++;
        end
        if (cause_task !== want.cause) begin
          $display("%0t: cause_task expected %0d, got %0d", $time, want.cause, cause_task);
          mismatches++;
        end
        if (last !== want.is_last) begin
          $display("%0t: last expected %0b, got %0b", $time, want.is_last, last);
          mismatches++;
        end
      end
    end
  end

  // Size zero hides every entry; fifteen acts as a full table.
  task automatic test_table_size_extremes();
    settle_block();
    program_table_size(4'd0);
    send_request(tbom_pkg::OP_LOAD, 3'd0, 6'd5, 32'd0, 1'b0);
    send_request(tbom_pkg::OP_START, 3'd0, 6'd0, 32'd0, 1'b0);
    send_request(tbom_pkg::OP_UPDATE, 3'd0, 6'd0, 32'd0, 1'b0);
    settle_block();
    program_table_size(4'd15);
    send_request(tbom_pkg::OP_UPDATE, 3'd0, 6'd0, 32'd0, 1'b0);
  endtask

  task automatic test_overrun_drops();
    settle_block();
    program_table_size(4'd8);
    send_request(tbom_pkg::OP_LOAD, 3'd0, 6'd63, 32'd0, 1'b0);
    send_request(tbom_pkg::OP_LOAD, 3'd3, 6'd63, 32'hFFFF_FFFF, 1'b1);
    send_request(tbom_pkg::OP_LOAD, 3'd7, 6'd42, 32'd0, 1'b1);
    send_request(tbom_pkg::OP_START, 3'd0, 6'd0, 32'd0, 1'b0);
    send_request(tbom_pkg::OP_START, 3'd3, 6'd0, 32'd0, 1'b0);
    send_request(tbom_pkg::OP_START, 3'd7, 6'd0, 32'd0, 1'b0);
    send_request(tbom_pkg::OP_TICK, 3'd0, 6'd0, 32'd0, 1'b0);
    send_request(tbom_pkg::OP_TICK, 3'd0, 6'd0, 32'd0, 1'b0);
    // duplicate priority: the lower index wins
    send_request(tbom_pkg::OP_PAUSE, 3'd0, 6'd63, 32'd0, 1'b0);
    send_request(tbom_pkg::OP_PAUSE, 3'd0, 6'd17, 32'd0, 1'b0);
    // reload keeps the running flag and the counter
    send_request(tbom_pkg::OP_LOAD, 3'd3, 6'd1, 32'hFFFF_FFFF, 1'b1);
    send_request(tbom_pkg::OP_PAUSE, 3'd0, 6'd1, 32'd0, 1'b0);
    send_request(tbom_pkg::OP_UNPAUSE, 3'd0, 6'd0, 32'd0, 1'b0);
    send_request(tbom_pkg::OP_TICK, 3'd0, 6'd0, 32'd0, 1'b0);
    // two overruns in one walk: the same tasks get reported twice
    send_request(tbom_pkg::OP_UPDATE, 3'd0, 6'd0, 32'd0, 1'b0);
    send_request(tbom_pkg::OP_END, 3'd7, 6'd0, 32'd0, 1'b0);
    send_request(tbom_pkg::OP_UPDATE, 3'd0, 6'd0, 32'd0, 1'b0);
    send_request(OP_UNUSED, 3'd7, 6'd63, 32'hFFFF_FFFF, 1'b1);
    send_request(tbom_pkg::OP_PAUSE, 3'd0, 6'd63, 32'd0, 1'b0);
    send_request(tbom_pkg::OP_PAUSE, 3'd0, 6'd0, 32'd0, 1'b0);
    send_request(tbom_pkg::OP_TICK, 3'd0, 6'd0, 32'd0, 1'b0);
    send_request(tbom_pkg::OP_UPDATE, 3'd0, 6'd0, 32'd0, 1'b0);
  endtask

  // Hold the result side off while a run of overruns backs up the input.
  task automatic test_result_backpressure();
    settle_block();
    program_table_size(4'd8);
    sender_gaps = 1'b0;
    rx_mode = RX_STEADY;
    send_request(tbom_pkg::OP_LOAD, 3'd0, 6'd9, 32'd0, 1'b1);
    for (int t = 1; t < MAX_T; t++)
      send_request(tbom_pkg::OP_LOAD, 3'(t), 6'(t), 32'd100, 1'b0);
    send_request(tbom_pkg::OP_START, 3'd0, 6'd0, 32'd0, 1'b0);
    -> holdoff_go;
    repeat (10) begin
      send_request(tbom_pkg::OP_UPDATE, 3'd0, 6'd0, 32'd0, 1'b0);
      send_request(tbom_pkg::OP_TICK, 3'd0, 6'd0, 32'd0, 1'b0);
    end
  endtask

  task automatic run_session(input int len);
    logic [tbom_pkg::OP_W-1:0] op;
    int k;
    for (int t = 0; t < MAX_T; t++)
      if ($urandom_range(0, 3) != 0)
        send_request(tbom_pkg::OP_LOAD, 3'(t), pick_prio(), pick_budget(),
                     $urandom_range(0, 2) == 0);
    for (int t = 0; t < MAX_T; t++)
      if ($urandom_range(0, 2) != 0)
        send_request(tbom_pkg::OP_START, 3'(t), pick_prio(), pick_budget(),
                     1'($urandom_range(0, 1)));
    repeat (len) begin
      k = $urandom_range(0, 99);
      if (k < 30)      op = tbom_pkg::OP_TICK;
      else if (k < 45) op = tbom_pkg::OP_START;
      else if (k < 53) op = tbom_pkg::OP_END;
      else if (k < 63) op = tbom_pkg::OP_PAUSE;
      else if (k < 68) op = tbom_pkg::OP_UNPAUSE;
      else if (k < 84) op = tbom_pkg::OP_UPDATE;
      else if (k < 96) op = tbom_pkg::OP_LOAD;
      else             op = OP_UNUSED;
      send_request(op, tbom_pkg::ID_W'($urandom_range(0, 7)), pick_prio(), pick_budget(),
                   1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_random_traffic();
    int sessions;
    sessions = 0;
    while (requests_sent < ITEM_TARGET && sessions < 200) begin
      settle_block();
      program_table_size(pick_size());
      sender_gaps = ($urandom_range(0, 3) != 0);
      rx_mode = $urandom_range(RX_STEADY, RX_PATTERN);
      run_session($urandom_range(15, 40));
      sessions++;
    end
  endtask

  initial begin
    clear_prediction();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_size_extremes();
    test_overrun_drops();
    test_result_backpressure();
    test_random_traffic();
    settle_block();
    $display("Covered %0d requests over %0d table sizes, with gaps, stalls and a long hold-off.",
             requests_sent, sizes_written);
    $display("Checked %0d suspend results against %0d predicted.", drops_checked, drops_expected);
    if (mismatches == 0) begin
      $display("task_budget_overrun_monitor verification clean");
    end else begin
      $display("task_budget_overrun_monitor verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d suspend results outstanding.", pending_drops.size());
    $display("task_budget_overrun_monitor verification failed");
    $finish;
  end

endmodule

@@ task_budget_overrun_monitor.f @@
design/tbom_pkg.sv
design/tbom_front.sv
design/tbom_back.sv
design/task_budget_overrun_monitor.sv
bench/testbench.sv
